// ===== src/ubgm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ubgm_pkg;

  // sizes
  localparam int GLYPH_BITS_DEF = 16;
  localparam int NUM_BLOCKS     = 88;
  localparam int BLK_W          = 7;
  localparam int COUNT_W        = 15;
  localparam int STORE_AW       = 16;
  localparam int STORE_DEPTH    = 1 << STORE_AW;

  localparam logic [15:0] LAST_ASSIGNED = 16'hFFFD;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_CP    = 2'd1;
  localparam logic [1:0] ST_ZERO_GLYPH = 2'd2;
  localparam logic [1:0] ST_UNASSIGNED = 2'd3;

  // request type codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // block range table, first and last code point of each block
  localparam logic [15:0] BLK_LO [NUM_BLOCKS] = '{
    16'h0000, 16'h0080, 16'h0100, 16'h0180, 16'h0250, 16'h02B0, 16'h0300, 16'h0370,
    16'h0400, 16'h0530, 16'h0590, 16'h0600, 16'h0700, 16'h0780, 16'h0900, 16'h0980,
    16'h0A00, 16'h0A80, 16'h0B00, 16'h0B80, 16'h0C00, 16'h0C80, 16'h0D00, 16'h0D80,
    16'h0E00, 16'h0E80, 16'h0F00, 16'h1000, 16'h10A0, 16'h1100, 16'h1200, 16'h13A0,
    16'h1400, 16'h1680, 16'h16A0, 16'h1780, 16'h1800, 16'h1E00, 16'h1F00, 16'h2000,
    16'h2070, 16'h20A0, 16'h20D0, 16'h2100, 16'h2150, 16'h2190, 16'h2200, 16'h2300,
    16'h2400, 16'h2440, 16'h2460, 16'h2500, 16'h2580, 16'h25A0, 16'h2600, 16'h2700,
    16'h2800, 16'h2E80, 16'h2F00, 16'h2FF0, 16'h3000, 16'h3040, 16'h30A0, 16'h3100,
    16'h3130, 16'h3190, 16'h31A0, 16'h3200, 16'h3300, 16'h3400, 16'h4E00, 16'hA000,
    16'hA490, 16'hAC00, 16'hD800, 16'hDB80, 16'hDC00, 16'hE000, 16'hF900, 16'hFB00,
    16'hFB50, 16'hFE20, 16'hFE30, 16'hFE50, 16'hFE70, 16'hFEFF, 16'hFF00, 16'hFFF0
  };

  localparam logic [15:0] BLK_HI [NUM_BLOCKS] = '{
    16'h007F, 16'h00FF, 16'h017F, 16'h024F, 16'h02AF, 16'h02FF, 16'h036F, 16'h03FF,
    16'h04FF, 16'h058F, 16'h05FF, 16'h06FF, 16'h074F, 16'h07BF, 16'h097F, 16'h09FF,
    16'h0A7F, 16'h0AFF, 16'h0B7F, 16'h0BFF, 16'h0C7F, 16'h0CFF, 16'h0D7F, 16'h0DFF,
    16'h0E7F, 16'h0EFF, 16'h0FFF, 16'h109F, 16'h10FF, 16'h11FF, 16'h137F, 16'h13FF,
    16'h167F, 16'h169F, 16'h16FF, 16'h17FF, 16'h18AF, 16'h1EFF, 16'h1FFF, 16'h206F,
    16'h209F, 16'h20CF, 16'h20FF, 16'h214F, 16'h218F, 16'h21FF, 16'h22FF, 16'h23FF,
    16'h243F, 16'h245F, 16'h24FF, 16'h257F, 16'h259F, 16'h25FF, 16'h26FF, 16'h27BF,
    16'h28FF, 16'h2EFF, 16'h2FDF, 16'h2FFF, 16'h303F, 16'h309F, 16'h30FF, 16'h312F,
    16'h318F, 16'h319F, 16'h31BF, 16'h32FF, 16'h33FF, 16'h4DB5, 16'h9FFF, 16'hA48F,
    16'hA4CF, 16'hD7A3, 16'hDB7F, 16'hDBFF, 16'hDFFF, 16'hF8FF, 16'hFAFF, 16'hFB4F,
    16'hFDFF, 16'hFE2F, 16'hFE4F, 16'hFE6F, 16'hFEFE, 16'hFEFF, 16'hFFEF, 16'hFFFD
  };

  // request item
  typedef struct packed {
    logic        req_type;
    logic [20:0] code_point;
    logic [15:0] glyph_in;
  } req_t;

  // result item
  typedef struct packed {
    logic [15:0]        glyph_out;
    logic [BLK_W-1:0]   block_index;
    logic               block_found;
    logic [COUNT_W-1:0] mapped_count;
    logic [1:0]         status;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic                load_req;
    logic                clear;
    logic [STORE_AW-1:0] clr_addr;
    logic                class_en;
    logic                cnt_rd;
    logic                exec;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/ubgm_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ubgm_classifier (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [20:0]               code_point,
  output logic [ubgm_pkg::BLK_W-1:0]     blk_idx,
  output logic                           blk_found
);

  logic [ubgm_pkg::NUM_BLOCKS-1:0] hit;
  logic                            in_range;
  logic [ubgm_pkg::BLK_W-1:0]      idx_enc;

  // nonzero and within the assigned plane range
  assign in_range = (code_point[20:16] == 5'd0) && (code_point != 21'd0) &&
                    (code_point[15:0] <= ubgm_pkg::LAST_ASSIGNED);

  // one comparator pair per block, ranges are disjoint
  always_comb begin
    for (int b = 0; b < ubgm_pkg::NUM_BLOCKS; b++) begin
      hit[b] = (code_point[15:0] >= ubgm_pkg::BLK_LO[b]) &&
               (code_point[15:0] <= ubgm_pkg::BLK_HI[b]);
    end
  end

  // encode the one-hot hit vector
  always_comb begin
    idx_enc = '0;
    for (int b = 0; b < ubgm_pkg::NUM_BLOCKS; b++) begin
      if (hit[b]) begin
        idx_enc = idx_enc | ubgm_pkg::BLK_W'(b);
      end
    end
  end

  // registered classification
  always_ff @(posedge clk) begin
    if (en) begin
      blk_found <= in_range && (|hit);
      blk_idx   <= (in_range && (|hit)) ? idx_enc : '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/ubgm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ubgm_datapath #(
  parameter int GLYPH_BITS = ubgm_pkg::GLYPH_BITS_DEF
) (
  input  wire logic           clk,
  input  wire ubgm_pkg::cmd_t cmd,
  input  wire ubgm_pkg::req_t req,
  output ubgm_pkg::rsp_t      rsp
);

  localparam int AW = ubgm_pkg::STORE_AW;
  localparam int BW = ubgm_pkg::BLK_W;
  localparam int CW = ubgm_pkg::COUNT_W;

  ubgm_pkg::req_t req_q;
  ubgm_pkg::rsp_t rsp_d;

  logic [GLYPH_BITS-1:0] store [ubgm_pkg::STORE_DEPTH];
  logic [CW-1:0]         cnt_mem [ubgm_pkg::NUM_BLOCKS];

  logic [GLYPH_BITS-1:0] store_rd;
  logic [CW-1:0]         cnt_q;
  logic [BW-1:0]         blk_idx;
  logic                  blk_found;

  logic [GLYPH_BITS-1:0] wdata;
  logic [31:0]           rd_ext;
  logic                  glyph_zero;
  logic                  is_insert;
  logic                  st_we;
  logic [AW-1:0]         st_waddr;
  logic [GLYPH_BITS-1:0] st_wd;
  logic                  cnt_we;
  logic                  cnt_inc;
  logic [BW-1:0]         cnt_waddr;
  logic [CW-1:0]         cnt_wd;
  logic [CW-1:0]         cnt_new;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
  end

  ubgm_classifier u_classifier (
    .clk        (clk),
    .en         (cmd.class_en),
    .code_point (req_q.code_point),
    .blk_idx    (blk_idx),
    .blk_found  (blk_found)
  );

  // glyph store read
  always_ff @(posedge clk) begin
    if (cmd.class_en) begin
      store_rd <= store[req_q.code_point[AW-1:0]];
    end
  end

  // block count read
  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) begin
      cnt_q <= cnt_mem[blk_idx];
    end
  end

  assign wdata      = GLYPH_BITS'(req_q.glyph_in);
  assign rd_ext     = 32'(store_rd);
  assign glyph_zero = (wdata == '0);
  assign is_insert  = (req_q.req_type == ubgm_pkg::REQ_INSERT);
  assign cnt_new    = cnt_inc ? (cnt_q + CW'(1)) : cnt_q;

  // result and commit decisions
  always_comb begin
    rsp_d   = '0;
    cnt_inc = 1'b0;
    st_we   = 1'b0;
    if (req_q.code_point == 21'd0) begin
      rsp_d.status = ubgm_pkg::ST_ZERO_CP;
    end else if (is_insert && glyph_zero) begin
      rsp_d.status       = ubgm_pkg::ST_ZERO_GLYPH;
      rsp_d.block_index  = blk_idx;
      rsp_d.block_found  = blk_found;
      rsp_d.mapped_count = blk_found ? cnt_q : '0;
    end else if (!blk_found) begin
      rsp_d.status = ubgm_pkg::ST_UNASSIGNED;
    end else begin
      rsp_d.status      = ubgm_pkg::ST_OK;
      rsp_d.block_index = blk_idx;
      rsp_d.block_found = 1'b1;
      if (is_insert) begin
        st_we              = 1'b1;
        cnt_inc            = (store_rd == '0);
        rsp_d.mapped_count = (store_rd == '0) ? (cnt_q + CW'(1)) : cnt_q;
      end else begin
        rsp_d.glyph_out    = rd_ext[15:0];
        rsp_d.mapped_count = cnt_q;
      end
    end
  end

  // write port muxing: clearing sweep or commit
  always_comb begin
    if (cmd.clear) begin
      st_waddr  = cmd.clr_addr;
      st_wd     = '0;
      cnt_waddr = cmd.clr_addr[BW-1:0];
      cnt_wd    = '0;
      cnt_we    = (cmd.clr_addr < AW'(ubgm_pkg::NUM_BLOCKS));
    end else begin
      st_waddr  = req_q.code_point[AW-1:0];
      st_wd     = wdata;
      cnt_waddr = blk_idx;
      cnt_wd    = cnt_new;
      cnt_we    = cmd.exec && cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear || (cmd.exec && st_we)) begin
      store[st_waddr] <= st_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp <= rsp_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ubgm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ubgm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output ubgm_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASS,
    S_READ,
    S_EXEC
  } state_t;

  state_t                        state;
  logic [ubgm_pkg::STORE_AW-1:0] clr_addr;
  logic                          go;

  // result register free or being taken this cycle
  assign go        = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // commands decoded from state
  always_comb begin
    cmd          = '0;
    cmd.load_req = (state == S_IDLE) && req_valid;
    cmd.clear    = (state == S_CLEAR);
    cmd.clr_addr = clr_addr;
    cmd.class_en = (state == S_CLASS);
    cmd.cnt_rd   = (state == S_READ);
    cmd.exec     = (state == S_EXEC) && go;
  end

  // sequencer, clear counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // accepted item always enters classification next
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_CLASS))
    else $error("accepted item did not start classification");

  // commit always produces a pending result
  a_exec_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid)
    else $error("commit without result valid");

  // a new result only appears after a commit cycle
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_EXEC))
    else $error("result valid rose outside commit");

  // clearing sweep ends exactly at the last address
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && clr_addr == '1) |=> (state == S_IDLE))
    else $error("clearing sweep did not finish");

endmodule

`default_nettype wire

// ===== src/unicode_block_glyph_map.sv =====
// items pass through the controller states in order: accept, classify and
//   glyph store read, block count read, then commit; a new item is accepted
//   only after the previous commit, which waits while a pending result is stalled
// reset: a clearing pass over all 65536 addresses zeroes the glyph store, block
//   counts are zeroed at the first 88 addresses; req_stall stays high throughout
`timescale 1ns / 1ps
`default_nettype none

module unicode_block_glyph_map #(
  parameter int GLYPH_BITS = ubgm_pkg::GLYPH_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire ubgm_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output ubgm_pkg::rsp_t      rsp
);

  ubgm_pkg::cmd_t cmd;

  ubgm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  ubgm_datapath #(
    .GLYPH_BITS (GLYPH_BITS)
  ) u_datapath (
    .clk (clk),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire
